// ----- rtl/interval_peak_load_macros.svh -----
// assertion macros shared by the interval peak load rtl
// expects clk and rst_n in the scope of each use
`ifndef INTERVAL_PEAK_LOAD_MACROS_SVH
`define INTERVAL_PEAK_LOAD_MACROS_SVH

// condition that holds at every clock edge out of reset
`define IPL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define IPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ipl_pkg.sv -----
// shared types and constants for the interval peak load block
// used by ipl_ctrl, ipl_dp and interval_peak_load; no dependencies
package ipl_pkg;

    localparam int SLOT_W   = 11;
    localparam int WEIGHT_W = 8;
    localparam int LOAD_W   = 16;
    localparam int IN_W     = 32;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT,
        ST_CLEAR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic walk_step;
        logic capture;
        logic clear_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic clear_done;
        logic last;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/ipl_ctrl.sv -----
// controller for the interval peak load block: walk, result and clear sequencing
// depends on ipl_pkg
module ipl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ipl_pkg::status_t  status,
    output ipl_pkg::cmd_t     cmd
);

    ipl_pkg::state_t state_reg;
    ipl_pkg::state_t state_next;

    // state register, reset starts with a sweep of the slot store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipl_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ipl_pkg::ST_WALK;
                end
            end
            ipl_pkg::ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = status.last ? ipl_pkg::ST_RESULT : ipl_pkg::ST_IDLE;
                end
            end
            ipl_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ipl_pkg::ST_CLEAR;
                end
            end
            ipl_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ipl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ipl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ipl_pkg::ST_WALK:
            begin
                cmd.walk_step = !status.walk_done;
            end
            ipl_pkg::ST_RESULT:
            begin
                cmd.capture = status.out_free;
            end
            ipl_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/ipl_dp.sv -----
// datapath for the interval peak load block: slot store, read-modify-write,
// running peak and result register; depends on ipl_pkg and the macros header
`include "interval_peak_load_macros.svh"

module ipl_dp #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipl_pkg::cmd_t                 cmd,
    output ipl_pkg::status_t              status,
    input  logic [ipl_pkg::SLOT_W-1:0]    start_slot,
    input  logic [ipl_pkg::SLOT_W-1:0]    end_slot,
    input  logic [ipl_pkg::WEIGHT_W-1:0]  weight,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ipl_pkg::LOAD_W-1:0]    peak_load
);

    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CW     = (CNT_W > ipl_pkg::SLOT_W) ? CNT_W : ipl_pkg::SLOT_W;

    logic [ipl_pkg::LOAD_W-1:0]   mem [SLOT_COUNT];

    logic [CW-1:0]                idx_reg;
    logic [CW-1:0]                idx_next;
    logic [CW-1:0]                hi_reg;
    logic [ipl_pkg::WEIGHT_W-1:0] weight_reg;
    logic                         last_reg;
    logic                         rd_v_reg;
    logic [ADDR_W-1:0]            wr_addr_reg;
    logic [ipl_pkg::LOAD_W-1:0]   rd_data_reg;
    logic [ipl_pkg::LOAD_W-1:0]   peak_reg;
    logic                         out_valid_reg;
    logic [ipl_pkg::LOAD_W-1:0]   out_data_reg;

    logic [CW-1:0]                lo_in;
    logic [CW-1:0]                hi_in;
    logic [ipl_pkg::SLOT_W-1:0]   start_m1;
    logic [ipl_pkg::SLOT_W-1:0]   end_m1;
    logic [ipl_pkg::LOAD_W:0]     sum_wide;
    logic [ipl_pkg::LOAD_W-1:0]   sum_sat;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [ipl_pkg::LOAD_W-1:0]   wr_data;

    // one-based slots to store indices, top clipped to the store size
    always_comb
    begin
        start_m1 = (start_slot == '0) ? '0 : start_slot - 1'b1;
        end_m1   = (end_slot == '0) ? '0 : end_slot - 1'b1;
        lo_in    = CW'(start_m1);
        hi_in    = CW'(end_m1);
        if (hi_in > CW'(SLOT_COUNT))
        begin
            hi_in = CW'(SLOT_COUNT);
        end
    end

    // saturating add on the slot read back last cycle
    always_comb
    begin
        sum_wide = {1'b0, rd_data_reg} + (ipl_pkg::LOAD_W + 1)'(weight_reg);
        sum_sat  = sum_wide[ipl_pkg::LOAD_W] ? ipl_pkg::LOAD_MAX
                                             : sum_wide[ipl_pkg::LOAD_W-1:0];
    end

    // store write port: pending update or clearing sweep
    always_comb
    begin
        wr_en   = rd_v_reg || cmd.clear_step;
        wr_addr = cmd.clear_step ? idx_reg[ADDR_W-1:0] : wr_addr_reg;
        wr_data = cmd.clear_step ? '0 : sum_sat;
    end

    // slot index: walks an interval, then sweeps the store after a result
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = lo_in;
        end
        else if (cmd.walk_step || cmd.clear_step)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.capture)
        begin
            idx_next = '0;
        end
    end

    // slot store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.walk_step)
        begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
    end

    // interval payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hi_reg     <= hi_in;
            weight_reg <= weight;
            last_reg   <= last;
        end
        if (cmd.walk_step)
        begin
            wr_addr_reg <= idx_reg[ADDR_W-1:0];
        end
        if (cmd.capture)
        begin
            out_data_reg <= peak_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_v_reg      <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            rd_v_reg <= cmd.walk_step;
            if (cmd.capture)
            begin
                peak_reg <= '0;
            end
            else if (rd_v_reg && (sum_sat > peak_reg))
            begin
                peak_reg <= sum_sat;
            end
            if (cmd.capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.walk_done  = !(idx_reg < hi_reg);
    assign status.clear_done = (idx_reg == CW'(SLOT_COUNT - 1));
    assign status.last       = last_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign peak_load = out_data_reg;

    // checks
    `IPL_ASSERT(a_no_write_clash, !(rd_v_reg && cmd.clear_step), "update collides with clear sweep")
    `IPL_ASSERT_IMPL(a_capture_drained, cmd.capture, !rd_v_reg && last_reg, "result taken before last update")
    `IPL_ASSERT_NEXT(a_peak_grows, !cmd.capture, peak_reg >= $past(peak_reg), "running peak dropped within a set")

endmodule

// ----- rtl/interval_peak_load.sv -----
// top level of the interval peak load block: stream ports, controller and datapath
// depends on ipl_pkg, ipl_ctrl and ipl_dp

// Takes one weighted interval per input beat and adds its weight, saturating at 65535, to
// every slot from start_slot up to end_slot - 1 (slots 1..SLOT_COUNT; out-of-range slots are
// ignored). On the beat marked tlast it emits the peak slot total of the set, then clears
// the slot store and the peak. The slot store is a single-port-write memory walked with one
// read-modify-write per cycle, and no beat is accepted until the walk of an interval is
// done. After a tlast beat the result is loaded, waiting while the previous result is still
// untaken, then a clearing pass over the whole slot store runs, during which no beat is
// accepted. The same clearing pass runs after reset.
module interval_peak_load #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ipl_pkg::IN_W-1:0]   s_tdata,   // start_slot, end_slot, weight, zero pad
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ipl_pkg::LOAD_W-1:0] m_tdata    // peak_load
);

    ipl_pkg::cmd_t    cmd;
    ipl_pkg::status_t status;

    // sequencing
    ipl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot store and peak
    ipl_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_slot (s_tdata[10:0]),
        .end_slot   (s_tdata[21:11]),
        .weight     (s_tdata[29:22]),
        .last       (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .peak_load  (m_tdata)
    );

endmodule

// ----- tb/ipl_checker.sv -----
// stream monitor and scoreboard for the interval peak load block
// predicts the peak of each interval set and compares it with m_tdata; uses ipl_pkg
`timescale 1ns / 100ps

module ipl_checker #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [ipl_pkg::IN_W-1:0]   s_tdata,   // start_slot, end_slot, weight, zero pad
    input  logic                       s_tlast,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [ipl_pkg::LOAD_W-1:0] m_tdata,   // peak_load
    output int                         fail_count,
    output int                         pending
);

    logic [ipl_pkg::LOAD_W-1:0] slot_load [SLOT_COUNT];
    logic [ipl_pkg::LOAD_W-1:0] set_peak;
    logic [ipl_pkg::LOAD_W-1:0] peak_due [$];

    task automatic clear_set();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_load[i] = '0;
        end
        set_peak = '0;
    endtask

    // add the weight over slots first .. stop-1, clipped to the store; close the set on tlast
    task automatic apply_interval(input logic [ipl_pkg::SLOT_W-1:0]   first,
                                  input logic [ipl_pkg::SLOT_W-1:0]   stop,
                                  input logic [ipl_pkg::WEIGHT_W-1:0] w,
                                  input logic                         closes);
        int lo;
        int hi;
        logic [ipl_pkg::LOAD_W:0] sum;
        lo = (first == 0) ? 0 : int'(first) - 1;
        hi = (stop == 0) ? 0 : int'(stop) - 1;
        if (hi > SLOT_COUNT)
        begin
            hi = SLOT_COUNT;
        end
        for (int i = lo; i < hi; i++)
        begin
            sum = {1'b0, slot_load[i]} + w;
            if (sum > ipl_pkg::LOAD_MAX)
            begin
                sum = {1'b0, ipl_pkg::LOAD_MAX};
            end
            slot_load[i] = sum[ipl_pkg::LOAD_W-1:0];
            if (sum[ipl_pkg::LOAD_W-1:0] > set_peak)
            begin
                set_peak = sum[ipl_pkg::LOAD_W-1:0];
            end
        end
        if (closes)
        begin
            peak_due = {peak_due, set_peak};
            clear_set();
        end
    endtask

    // sample both channels at each edge; results first, then the new beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_set();
            peak_due.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (peak_due.size() == 0)
                begin
                    $error("peak_load: no result expected, actual %0d", m_tdata);
                    fail_count++;
                end
                else
                begin
                    if (m_tdata !== peak_due[0])
                    begin
                        $error("peak_load: expected %0d, actual %0d", peak_due[0], m_tdata);
                        fail_count++;
                    end
                    void'(peak_due.pop_front());
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_interval(s_tdata[ipl_pkg::SLOT_W-1:0],
                               s_tdata[2*ipl_pkg::SLOT_W-1:ipl_pkg::SLOT_W],
                               s_tdata[2*ipl_pkg::SLOT_W+ipl_pkg::WEIGHT_W-1:2*ipl_pkg::SLOT_W],
                               s_tlast);
            end
            pending <= peak_due.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// top of the interval peak load testbench: clock, reset, stimulus and verdict
// instantiates interval_peak_load and ipl_checker; uses ipl_pkg
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOT_COUNT   = 1024;
    localparam int RANDOM_ITEMS = 560;
    localparam int SAT_ITEMS    = 285;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [ipl_pkg::IN_W-1:0]   s_tdata  = '0;   // start_slot, end_slot, weight, zero pad
    logic                       s_tlast  = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [ipl_pkg::LOAD_W-1:0] m_tdata;         // peak_load
    logic                       calm     = 1'b0;
    int                         fail_count;
    int                         pending;

    interval_peak_load #(.SLOT_COUNT(SLOT_COUNT)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ipl_checker #(.SLOT_COUNT(SLOT_COUNT)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // random back-pressure on the result side, none in a calm stretch
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 37);
    end

    // one interval beat, with a random gap before it unless calm
    task automatic send_interval(input logic [ipl_pkg::SLOT_W-1:0]   first,
                                 input logic [ipl_pkg::SLOT_W-1:0]   stop,
                                 input logic [ipl_pkg::WEIGHT_W-1:0] w,
                                 input logic                         closes);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ipl_pkg::IN_W-2*ipl_pkg::SLOT_W-ipl_pkg::WEIGHT_W){1'b0}},
                     w, stop, first};
        s_tlast  <= closes;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the sender until every expected peak has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        int                           sent;
        int                           set_len;
        int                           kind;
        bit                           saturated;
        logic [ipl_pkg::SLOT_W-1:0]   first;
        logic [ipl_pkg::SLOT_W-1:0]   stop;
        logic [ipl_pkg::WEIGHT_W-1:0] w;
        sent = 0;
        saturated = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full store, out-of-range ends, empty and reversed intervals
        send_interval(11'd1, 11'd1025, 8'd255, 1'b0);
        send_interval(11'd0, 11'd2047, 8'd1, 1'b0);
        send_interval(11'd5, 11'd5, 8'd255, 1'b0);
        send_interval(11'd10, 11'd3, 8'd200, 1'b1);
        // zero weight only, then a set with nothing covered
        send_interval(11'd1, 11'd2, 8'd0, 1'b1);
        send_interval(11'd0, 11'd0, 8'd0, 1'b1);
        send_interval(11'd2047, 11'd2047, 8'd255, 1'b1);
        // top slot, then an interval wholly beyond the store
        send_interval(11'd1024, 11'd1025, 8'd255, 1'b0);
        send_interval(11'd1025, 11'd2047, 8'd255, 1'b1);
        // overlap on the first slot
        send_interval(11'd1, 11'd2, 8'd128, 1'b0);
        send_interval(11'd1, 11'd3, 8'd127, 1'b1);
        send_interval(11'd3, 11'd1024, 8'd85, 1'b1);
        // alternating bit patterns in every field
        send_interval(11'h555, 11'h2aa, 8'h55, 1'b0);
        send_interval(11'h2aa, 11'h555, 8'haa, 1'b0);
        send_interval(11'h7ff, 11'h400, 8'hff, 1'b1);
        drain_results();

        // random sets of intervals, one saturating set among them
        while (sent < RANDOM_ITEMS)
        begin
            calm <= (sent >= 60 && sent < 160);
            if (!saturated && sent >= 200)
            begin
                for (int k = 0; k < SAT_ITEMS; k++)
                begin
                    send_interval(11'($urandom_range(1, 2)), 11'($urandom_range(3, 4)),
                                  8'($urandom_range(240, 255)), k == SAT_ITEMS - 1);
                end
                sent += SAT_ITEMS;
                saturated = 1;
            end
            else
            begin
                set_len = $urandom_range(1, 12);
                for (int k = 0; k < set_len; k++)
                begin
                    kind = $urandom_range(0, 99);
                    if (kind < 65)
                    begin
                        first = 11'($urandom_range(1, SLOT_COUNT));
                        stop  = first + 11'($urandom_range(0, 40));
                    end
                    else if (kind < 80)
                    begin
                        first = 11'($urandom_range(1, 24));
                        stop  = first + 11'($urandom_range(1, 16));
                    end
                    else if (kind < 88)
                    begin
                        first = 11'($urandom_range(0, 2047));
                        stop  = 11'($urandom_range(0, first));
                    end
                    else if (kind < 94)
                    begin
                        first = 11'($urandom_range(1000, 2047));
                        stop  = 11'($urandom_range(1000, 2047));
                    end
                    else if (kind < 97)
                    begin
                        first = 11'($urandom_range(0, 2047));
                        stop  = 11'($urandom_range(0, 2047));
                    end
                    else
                    begin
                        first = 11'($urandom_range(0, 1));
                        stop  = 11'($urandom_range(1025, 2047));
                    end
                    kind = $urandom_range(0, 9);
                    w = (kind == 0) ? 8'd0 : (kind == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                    send_interval(first, stop, w, k == set_len - 1);
                end
                sent += set_len;
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        calm     <= 1'b0;

        // let the last set drain and its clearing pass finish
        drain_results();
        repeat (SLOT_COUNT + 32) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // overall time limit
    initial
    begin
        #200000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
